@@ rtl/assert_macros.svh @@
// Assertion macros used by the frame extractor RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_SYNC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/frx_pkg.sv @@
// Package for the receive ring frame extractor: codes, payload structs, constants.
// No dependencies; used by every module of the block except frx_ram.
`timescale 1ns / 1ps

package frx_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int HEADER_LEN_DEF = 16;
    localparam int MAX_FRAME_DEF  = 64;

    localparam int HDR_WORDS  = 4;
    localparam int HDR_BITS   = HDR_WORDS * 32;
    localparam int HDR_IDX_W  = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int FLEN_W     = 7;

    localparam logic [31:0] HDR_RESET_0 = 32'h446E_6146;
    localparam logic [31:0] HDR_RESET_1 = 32'h6F6E_6975;
    localparam logic [31:0] HDR_RESET_2 = 32'h6165_482D;
    localparam logic [31:0] HDR_RESET_3 = 32'h3072_6564;

    localparam logic [CFG_IDX_W-1:0] REG_HDR_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_3 = 4'd3;

    typedef enum logic [1:0] {
        CMD_RECV  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_FETCH = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NOFRAME  = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_ACCEPTED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_PAY_RD,
        S_PAY_OUT
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [7:0]        rx_byte;
        logic [FLEN_W-1:0] frame_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_out_item;

endpackage

@@ rtl/frx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module frx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/frx_byte_cmp.sv @@
// Shared byte comparator: selects header byte by index and matches it to a stored byte.
// Depends on frx_pkg.
`timescale 1ns / 1ps

module frx_byte_cmp (
    input  logic [frx_pkg::HDR_BITS-1:0]  i_hdr,
    input  logic [frx_pkg::HDR_IDX_W-1:0] i_idx,
    input  logic [7:0]                    i_byte,
    output logic                          o_match
);

    logic [7:0] w_hdr_byte;

    // byte k sits at bit 8*k of the flattened header words
    assign w_hdr_byte = i_hdr[{i_idx, 3'b000} +: 8];
    assign o_match    = (w_hdr_byte == i_byte);

endmodule

@@ rtl/frx_seq.sv @@
// Command sequencer: ring pointers, header search and payload readout.
// Depends on frx_pkg, frx_ram, frx_byte_cmp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frx_seq #(
    parameter int DEPTH      = frx_pkg::DEPTH_DEF,
    parameter int HEADER_LEN = frx_pkg::HEADER_LEN_DEF,
    parameter int MAX_FRAME  = frx_pkg::MAX_FRAME_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  frx_pkg::t_in_item            i_in,
    input  logic [frx_pkg::HDR_BITS-1:0] i_hdr,
    output logic                         o_res_valid,
    output frx_pkg::t_out_item           o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int FW = frx_pkg::FLEN_W;

    frx_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_rp, n_rp;
    logic [AW-1:0]      r_wp, n_wp;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_off, n_off;
    logic [CW-1:0]      r_s, n_s;
    logic [FW-1:0]      r_k, n_k;
    logic [FW-1:0]      r_flen, n_flen;
    logic               r_res_valid, n_res_valid;
    frx_pkg::t_out_item r_out, n_out;

    logic          w_we;
    logic [AW-1:0] w_rd_addr;
    logic [SW-1:0] w_sum;
    logic [7:0]    w_rdata;
    logic          w_match;
    logic [AW-1:0] w_rp_inc;
    logic [AW-1:0] w_wp_inc;

    // read address = read pointer + offset, wrapped once
    assign w_sum     = SW'(r_rp) + SW'(r_off);
    assign w_rd_addr = (w_sum >= SW'(DEPTH)) ? AW'(w_sum - SW'(DEPTH)) : AW'(w_sum);
    assign w_rp_inc  = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
    assign w_wp_inc  = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);

    frx_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (i_in.rx_byte),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    frx_byte_cmp u_cmp (
        .i_hdr   (i_hdr),
        .i_idx   (r_k[frx_pkg::HDR_IDX_W-1:0]),
        .i_byte  (w_rdata),
        .o_match (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frx_pkg::S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_s         <= '0;
            r_k         <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_off       <= n_off;
            r_s         <= n_s;
            r_k         <= n_k;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flen <= n_flen;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_count     = r_count;
        n_off       = r_off;
        n_s         = r_s;
        n_k         = r_k;
        n_flen      = r_flen;
        n_res_valid = 1'b0;
        n_out       = r_out;
        w_we        = 1'b0;

        unique case (r_state)
            frx_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_in.cmd)
                        frx_pkg::CMD_RECV: begin
                            n_res_valid = 1'b1;
                            n_out.data  = 8'd0;
                            n_out.last  = 1'b1;
                            if (r_count < CW'(DEPTH)) begin
                                w_we         = 1'b1;
                                n_wp         = w_wp_inc;
                                n_count      = r_count + CW'(1);
                                n_out.status = frx_pkg::ST_ACCEPTED;
                            end else begin
                                n_out.status = frx_pkg::ST_DROPPED;
                            end
                        end
                        frx_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_res_valid  = 1'b1;
                                n_out.data   = 8'd0;
                                n_out.status = frx_pkg::ST_EMPTY;
                                n_out.last   = 1'b1;
                            end else begin
                                // read of the oldest byte is issued this cycle
                                n_state = frx_pkg::S_POP;
                            end
                        end
                        frx_pkg::CMD_FETCH: begin
                            n_flen = i_in.frame_length;
                            if (i_in.frame_length == '0 ||
                                i_in.frame_length > FW'(MAX_FRAME) ||
                                r_count < CW'(HEADER_LEN)) begin
                                n_res_valid  = 1'b1;
                                n_out.data   = 8'd0;
                                n_out.status = frx_pkg::ST_NOFRAME;
                                n_out.last   = 1'b1;
                            end else begin
                                n_s     = '0;
                                n_k     = '0;
                                n_off   = '0;
                                n_state = frx_pkg::S_SRCH_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            frx_pkg::S_POP: begin
                n_res_valid  = 1'b1;
                n_out.data   = w_rdata;
                n_out.status = frx_pkg::ST_OK;
                n_out.last   = 1'b1;
                n_rp         = w_rp_inc;
                n_count      = r_count - CW'(1);
                n_state      = frx_pkg::S_IDLE;
            end
            frx_pkg::S_SRCH_RD: begin
                n_state = frx_pkg::S_SRCH_CMP;
            end
            frx_pkg::S_SRCH_CMP: begin
                if (w_match) begin
                    if (r_k == FW'(HEADER_LEN - 1)) begin
                        // header found: payload must lie fully in held bytes
                        if (SW'(r_s) + SW'(HEADER_LEN) + SW'(r_flen) > SW'(r_count)) begin
                            n_res_valid  = 1'b1;
                            n_out.data   = 8'd0;
                            n_out.status = frx_pkg::ST_NOFRAME;
                            n_out.last   = 1'b1;
                            n_off        = '0;
                            n_state      = frx_pkg::S_IDLE;
                        end else begin
                            n_off   = r_s + CW'(HEADER_LEN);
                            n_k     = '0;
                            n_state = frx_pkg::S_PAY_RD;
                        end
                    end else begin
                        n_k     = r_k + FW'(1);
                        n_off   = r_off + CW'(1);
                        n_state = frx_pkg::S_SRCH_RD;
                    end
                end else begin
                    // advance the start position; stop when no header fits
                    if (SW'(r_s) + SW'(1) + SW'(HEADER_LEN) > SW'(r_count)) begin
                        n_res_valid  = 1'b1;
                        n_out.data   = 8'd0;
                        n_out.status = frx_pkg::ST_NOFRAME;
                        n_out.last   = 1'b1;
                        n_off        = '0;
                        n_state      = frx_pkg::S_IDLE;
                    end else begin
                        n_s     = r_s + CW'(1);
                        n_off   = r_s + CW'(1);
                        n_k     = '0;
                        n_state = frx_pkg::S_SRCH_RD;
                    end
                end
            end
            frx_pkg::S_PAY_RD: begin
                n_state = frx_pkg::S_PAY_OUT;
            end
            frx_pkg::S_PAY_OUT: begin
                n_res_valid  = 1'b1;
                n_out.data   = w_rdata;
                n_out.status = frx_pkg::ST_OK;
                n_out.last   = (r_k == r_flen - FW'(1));
                if (r_k == r_flen - FW'(1)) begin
                    // frame delivered: empty the ring
                    n_rp    = '0;
                    n_wp    = '0;
                    n_count = '0;
                    n_off   = '0;
                    n_state = frx_pkg::S_IDLE;
                end else begin
                    n_k     = r_k + FW'(1);
                    n_off   = r_off + CW'(1);
                    n_state = frx_pkg::S_PAY_RD;
                end
            end
            default: begin
                n_state = frx_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != frx_pkg::S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_out;

    `ASSERT_SYNC_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(DEPTH), "held count above depth")
    `ASSERT_SYNC(a_ptr_range, i_clk, i_rst_n, (SW'(r_rp) < SW'(DEPTH)) && (SW'(r_wp) < SW'(DEPTH)), "ring pointer out of range")
    `ASSERT_SYNC(a_last_idle, i_clk, i_rst_n, (r_res_valid && r_out.last) |-> (r_state == frx_pkg::S_IDLE), "final result while command still running")
    `ASSERT_SYNC(a_mid_payload, i_clk, i_rst_n, (r_res_valid && !r_out.last) |-> (r_state == frx_pkg::S_PAY_RD), "non-final result outside payload readout")
    `ASSERT_SYNC(a_idle_off, i_clk, i_rst_n, (r_state == frx_pkg::S_IDLE) |-> (r_off == '0), "offset not cleared in idle")

endmodule

@@ rtl/rx_ring_frame_sync_extract_top.sv @@
// Receive writes the byte in idle and registers its result; pop reads the oldest byte in idle
// and returns it from S_POP; fetch runs S_SRCH_RD, S_SRCH_CMP per header byte compared and
// S_PAY_RD, S_PAY_OUT per payload byte; one ring RAM read port and one byte comparator serve
// every step. Results are strobed one cycle each on o_res_valid; the receiver cannot stall.
// Synchronous active-low reset empties the ring and loads the default header words.
`timescale 1ns / 1ps

module rx_ring_frame_sync_extract_top #(
    parameter int DEPTH      = frx_pkg::DEPTH_DEF,
    parameter int HEADER_LEN = frx_pkg::HEADER_LEN_DEF,
    parameter int MAX_FRAME  = frx_pkg::MAX_FRAME_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  frx_pkg::t_in_item             i_in,
    output logic                          o_res_valid,
    output frx_pkg::t_out_item            o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [frx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    logic [frx_pkg::HDR_WORDS-1:0][31:0] r_hdr;
    logic [frx_pkg::HDR_WORDS-1:0][31:0] n_hdr;

    always_comb begin
        n_hdr = r_hdr;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                frx_pkg::REG_HDR_0: n_hdr[0] = i_cfg_data;
                frx_pkg::REG_HDR_1: n_hdr[1] = i_cfg_data;
                frx_pkg::REG_HDR_2: n_hdr[2] = i_cfg_data;
                frx_pkg::REG_HDR_3: n_hdr[3] = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr[0] <= frx_pkg::HDR_RESET_0;
            r_hdr[1] <= frx_pkg::HDR_RESET_1;
            r_hdr[2] <= frx_pkg::HDR_RESET_2;
            r_hdr[3] <= frx_pkg::HDR_RESET_3;
        end else begin
            r_hdr <= n_hdr;
        end
    end

    assign o_cfg_ready = 1'b1;

    frx_seq #(
        .DEPTH      (DEPTH),
        .HEADER_LEN (HEADER_LEN),
        .MAX_FRAME  (MAX_FRAME)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_in        (i_in),
        .i_hdr       (r_hdr),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rx_ring_frame_sync_extract_top: receive, pop and fetch commands
// are checked against a ring buffer predictor across several header settings.
// Depends on frx_pkg and the top module only.

module tb;
    import frx_pkg::*;

    localparam int   RING_DEPTH    = DEPTH_DEF;
    localparam int   HDR_LEN       = HEADER_LEN_DEF;
    localparam int   FRAME_MAX     = MAX_FRAME_DEF;
    localparam t_cmd CMD_UNUSED    = t_cmd'(2'd3);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_HDR_3 + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
    localparam int   QUIET_MIN     = 16;
    localparam int   WD_LIMIT      = 40000;
    localparam int   TAIL_CYC      = 64;
    localparam int   ERR_PRINT_MAX = 20;

    typedef struct {
        bit                   is_cfg;
        t_in_item             item;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          wdata;
        int                   gap_pct;
    } t_pending;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_in_item             i_in        = '0;
    logic                 o_res_valid;
    t_out_item            o_res;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;

    rx_ring_frame_sync_extract_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // pending commands and header writes, in issue order
    t_pending  cmd_fifo[$];
    // results the ring must still produce
    t_out_item due_res_q[$];

    // predictor state
    logic [7:0]          ring_mem [0:RING_DEPTH-1];
    int                  ring_rd   = 0;
    int                  ring_wr   = 0;
    int                  ring_held = 0;
    logic [HDR_BITS-1:0] hdr_bits  = {HDR_RESET_3, HDR_RESET_2, HDR_RESET_1, HDR_RESET_0};

    // generator view of the header currently programmed
    logic [HDR_BITS-1:0] gen_hdr   = {HDR_RESET_3, HDR_RESET_2, HDR_RESET_1, HDR_RESET_0};
    int                  cur_gap   = 32;
    int                  n_gen     = 0;

    logic cmd_acc   = 1'b0;
    logic cfg_acc   = 1'b0;
    int   quiet_cyc = 0;
    int   idle_wd   = 0;
    int   n_err     = 0;
    int   n_res     = 0;
    int   n_frames  = 0;
    int   n_cfg     = 0;
    int   n_recv    = 0;
    int   n_pop     = 0;
    int   n_fetch   = 0;
    int   n_unused  = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void push_res(logic [7:0] d, t_status s, logic l);
        t_out_item r;
        r.data   = d;
        r.status = s;
        r.last   = l;
        due_res_q.push_back(r);
    endfunction

    function automatic void ring_step(t_in_item it);
        int fl;
        int s;
        int k;
        int base;
        bit hit;
        fl = it.frame_length;
        case (it.cmd)
            CMD_RECV: begin
                if (ring_held < RING_DEPTH) begin
                    ring_mem[ring_wr] = it.rx_byte;
                    ring_wr = (ring_wr + 1) % RING_DEPTH;
                    ring_held++;
                    push_res(8'h00, ST_ACCEPTED, 1'b1);
                end else begin
                    push_res(8'h00, ST_DROPPED, 1'b1);
                end
            end
            CMD_POP: begin
                if (ring_held == 0) begin
                    push_res(8'h00, ST_EMPTY, 1'b1);
                end else begin
                    push_res(ring_mem[ring_rd], ST_OK, 1'b1);
                    ring_rd = (ring_rd + 1) % RING_DEPTH;
                    ring_held--;
                end
            end
            CMD_FETCH: begin
                base = -1;
                // only the first header match counts
                if (fl >= 1 && fl <= FRAME_MAX) begin
                    for (s = 0; s + HDR_LEN <= ring_held && base < 0; s++) begin
                        hit = 1'b1;
                        for (k = 0; k < HDR_LEN; k++) begin
                            if (ring_mem[(ring_rd + s + k) % RING_DEPTH] !== hdr_bits[8*k +: 8])
                                hit = 1'b0;
                        end
                        if (hit)
                            base = s + HDR_LEN;
                    end
                end
                if (base < 0 || base + fl > ring_held) begin
                    push_res(8'h00, ST_NOFRAME, 1'b1);
                end else begin
                    for (k = 0; k < fl; k++)
                        push_res(ring_mem[(ring_rd + base + k) % RING_DEPTH], ST_OK,
                                 k == fl - 1);
                    for (k = 0; k < RING_DEPTH; k++)
                        ring_mem[k] = 8'h00;
                    ring_rd   = 0;
                    ring_wr   = 0;
                    ring_held = 0;
                    n_frames++;
                end
            end
            default: ;
        endcase
    endfunction

    // sample transactions and results
    always @(posedge i_clk) begin
        t_out_item exp_r;
        logic      act;
        act = 1'b0;
        if (!i_rst_n) begin
            cmd_acc   <= 1'b0;
            cfg_acc   <= 1'b0;
            quiet_cyc <= 0;
            idle_wd   <= 0;
        end else begin
            cmd_acc <= start && !busy;
            cfg_acc <= i_cfg_valid && o_cfg_ready;
            if (start && !busy) begin
                act = 1'b1;
                case (i_in.cmd)
                    CMD_RECV:  n_recv++;
                    CMD_POP:   n_pop++;
                    CMD_FETCH: n_fetch++;
                    default:   n_unused++;
                endcase
                ring_step(i_in);
                void'(cmd_fifo.pop_front());
            end
            if (i_cfg_valid && o_cfg_ready) begin
                act = 1'b1;
                n_cfg++;
                if (i_cfg_index <= REG_HDR_3)
                    hdr_bits[32*i_cfg_index +: 32] = i_cfg_data;
                void'(cmd_fifo.pop_front());
            end
            if (o_res_valid === 1'b1) begin
                act = 1'b1;
                n_res++;
                if (due_res_q.size() == 0) begin
                    n_err++;
                    if (n_err <= ERR_PRINT_MAX)
                        $display("%0t: expected no result, got data %02h st %0d last %0b",
                                 $time, o_res.data, o_res.status, o_res.last);
                end else begin
                    exp_r = due_res_q.pop_front();
                    if (o_res.data !== exp_r.data || o_res.status !== exp_r.status ||
                        o_res.last !== exp_r.last) begin
                        n_err++;
                        if (n_err <= ERR_PRINT_MAX)
                            $display("%0t: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                                     $time, exp_r.data, exp_r.status, exp_r.last,
                                     o_res.data, o_res.status, o_res.last);
                    end
                end
            end
            quiet_cyc <= act ? 0 : quiet_cyc + 1;
            idle_wd   <= act ? 0 : idle_wd + 1;
        end
    end

    // drive the next pending transaction
    always @(negedge i_clk) begin
        t_pending nxt;
        bit       go_cmd;
        bit       go_cfg;
        go_cmd = 1'b0;
        go_cfg = 1'b0;
        if (i_rst_n && !(start && !cmd_acc) && !(i_cfg_valid && !cfg_acc)) begin
            if (cmd_fifo.size() != 0) begin
                nxt = cmd_fifo[0];
                if ($urandom_range(99) >= nxt.gap_pct) begin
                    if (!nxt.is_cfg)
                        go_cmd = 1'b1;
                    // header writes only on an idle ring
                    else if (due_res_q.size() == 0 && quiet_cyc >= QUIET_MIN && !busy)
                        go_cfg = 1'b1;
                end
            end
            start       <= go_cmd;
            i_cfg_valid <= go_cfg;
            if (go_cmd)
                i_in <= nxt.item;
            if (go_cfg) begin
                i_cfg_index <= nxt.idx;
                i_cfg_data  <= nxt.wdata;
            end
        end
    end

    function automatic void add_cmd(t_cmd c, logic [7:0] b, logic [FLEN_W-1:0] fl);
        t_pending p;
        p.is_cfg            = 1'b0;
        p.item.cmd          = c;
        p.item.rx_byte      = b;
        p.item.frame_length = fl;
        p.idx               = '0;
        p.wdata             = '0;
        p.gap_pct           = cur_gap;
        cmd_fifo.push_back(p);
        if (c != CMD_UNUSED)
            n_gen++;
    endfunction

    function automatic void add_recv(logic [7:0] b);
        add_cmd(CMD_RECV, b, FLEN_W'($urandom));
    endfunction

    function automatic void add_pops(int n);
        repeat (n) add_cmd(CMD_POP, 8'($urandom), FLEN_W'($urandom));
    endfunction

    function automatic void add_fetch(logic [FLEN_W-1:0] fl);
        add_cmd(CMD_FETCH, 8'($urandom), fl);
    endfunction

    function automatic void add_noise(int n);
        repeat (n) add_recv(8'($urandom));
    endfunction

    // send the header; flip one byte at bad_pos to break it (-1 keeps it whole)
    function automatic void add_hdr(int bad_pos);
        logic [7:0] b;
        for (int k = 0; k < HDR_LEN; k++) begin
            b = gen_hdr[8*k +: 8];
            if (k == bad_pos)
                b = b ^ 8'h01;
            add_recv(b);
        end
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        t_pending p;
        p.is_cfg  = 1'b1;
        p.item    = '0;
        p.idx     = idx;
        p.wdata   = d;
        p.gap_pct = cur_gap;
        cmd_fifo.push_back(p);
        if (idx <= REG_HDR_3)
            gen_hdr[32*idx +: 32] = d;
    endfunction

    function automatic void add_hdr_words(logic [31:0] w0, logic [31:0] w1,
                                          logic [31:0] w2, logic [31:0] w3);
        add_cfg(REG_HDR_0, w0);
        add_cfg(REG_HDR_1, w1);
        add_cfg(REG_HDR_2, w2);
        add_cfg(REG_HDR_3, w3);
    endfunction

    function automatic int pick_flen();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(12, 1);
        else if (r < 95)
            return $urandom_range(FRAME_MAX - 1, 13);
        return FRAME_MAX;
    endfunction

    function automatic void gen_burst();
        int sel;
        int nz;
        int fl;
        int cut;
        sel = $urandom_range(99);
        nz  = $urandom_range(4);
        fl  = pick_flen();
        if (sel < 55) begin
            add_noise(nz);
            add_hdr(-1);
            add_noise(fl + $urandom_range(2));
            add_fetch(FLEN_W'(fl));
        end else if (sel < 65) begin
            add_noise(nz);
            add_hdr($urandom_range(HDR_LEN - 1));
            add_noise(fl);
            add_fetch(FLEN_W'(fl));
            add_pops(nz + HDR_LEN + fl + 1);
        end else if (sel < 72) begin
            // first header match lacks payload bytes
            fl  = (fl < 2) ? 2 : fl;
            cut = $urandom_range(fl - 1, 1);
            add_noise(nz);
            add_hdr(-1);
            add_noise(fl - cut);
            add_fetch(FLEN_W'(fl));
            add_pops(nz + HDR_LEN + fl + 1);
        end else if (sel < 78) begin
            add_noise(nz);
            add_hdr(-1);
            add_noise(fl);
            add_fetch(FLEN_W'($urandom_range(1) ? 0 : $urandom_range(127, FRAME_MAX + 1)));
            add_fetch(FLEN_W'(fl));
        end else if (sel < 88) begin
            add_pops($urandom_range(5, 1));
        end else if (sel < 94) begin
            add_noise($urandom_range(4, 1));
            add_cmd(CMD_UNUSED, 8'($urandom), FLEN_W'($urandom));
        end else begin
            add_fetch(FLEN_W'($urandom));
        end
    endfunction

    function automatic void run_random(int n);
        int goal;
        goal = n_gen + n;
        while (n_gen < goal)
            gen_burst();
    endfunction

    // fill past capacity so bytes drop, with the payload wrapping the ring end
    function automatic void fill_ring();
        add_noise(230);
        add_pops(16);
        add_hdr(-1);
        add_noise(30);
        add_fetch(FLEN_W'(24));
    endfunction

    initial begin
        // empty ring, unused command, byte extremes, bad length, shortest frame
        add_pops(1);
        add_fetch(FLEN_W'(5));
        add_cmd(CMD_UNUSED, 8'hFF, '1);
        add_recv(8'h00);
        add_recv(8'hFF);
        add_pops(2);
        add_fetch(FLEN_W'(0));
        add_hdr(-1);
        add_recv(8'($urandom));
        add_fetch(FLEN_W'(1));
        run_random(10);

        add_hdr_words(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_cfg(REG_SPARE_LO, $urandom);
        add_cfg(REG_SPARE_HI, $urandom);
        run_random(10);

        // no idling in this stretch
        cur_gap = 0;
        add_hdr_words('1, '1, '1, '1);
        run_random(40);
        cur_gap = 32;

        add_hdr_words($urandom, $urandom, $urandom, $urandom);
        run_random(5);
        fill_ring();
        run_random(10);

        add_hdr_words(HDR_RESET_0, HDR_RESET_1, HDR_RESET_2, HDR_RESET_3);
        run_random(10);

        while (cmd_fifo.size() != 0 || due_res_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYC) @(negedge i_clk);

        $display("Ran %0d receive, %0d pop, %0d fetch and %0d unused commands;",
                 n_recv, n_pop, n_fetch, n_unused);
        $display("%0d register writes, %0d frames extracted, %0d results checked, %0d mismatches.",
                 n_cfg, n_frames, n_res, n_err);
        if (n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // stop a hung run
    initial begin
        while (idle_wd < WD_LIMIT)
            @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles, %0d results still due",
                 $time, WD_LIMIT, due_res_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
